// ===== rtl/info_frame_deframer_checker_macros.svh =====
// Assertion macros for the info frame deframer and checker.
// Included by the top level, which carries the concurrent assertions; needs clk and rst_n in scope.
`ifndef INFO_FRAME_DEFRAMER_CHECKER_MACROS_SVH
`define INFO_FRAME_DEFRAMER_CHECKER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define IFDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define IFDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ifdc_pkg.sv =====
// Shared types and constants for the info frame deframer and checker.
// No dependencies; imported by the interfaces' users, the parser and the top level.
package ifdc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 12;
    localparam int unsigned INDEX_W = 3;

    // Largest payload given out per frame.
    localparam logic [COUNT_W-1:0] MAX_PAYLOAD = COUNT_W'(2048);

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] CFG_FLAG    = 3'd0;
    localparam logic [INDEX_W-1:0] CFG_ESCAPE  = 3'd1;
    localparam logic [INDEX_W-1:0] CFG_MASK    = 3'd2;
    localparam logic [INDEX_W-1:0] CFG_ADDRESS = 3'd3;
    localparam logic [INDEX_W-1:0] CFG_CTRL0   = 3'd4;
    localparam logic [INDEX_W-1:0] CFG_CTRL1   = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] RST_FLAG    = 8'h7E;
    localparam logic [BYTE_W-1:0] RST_ESCAPE  = 8'h7D;
    localparam logic [BYTE_W-1:0] RST_MASK    = 8'h20;
    localparam logic [BYTE_W-1:0] RST_ADDRESS = 8'h03;
    localparam logic [BYTE_W-1:0] RST_CTRL0   = 8'h00;
    localparam logic [BYTE_W-1:0] RST_CTRL1   = 8'h40;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_BODY
    } phase_t;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_value;
        logic [BYTE_W-1:0] escape_value;
        logic [BYTE_W-1:0] stuff_mask;
        logic [BYTE_W-1:0] address_value;
        logic [BYTE_W-1:0] control_seq0;
        logic [BYTE_W-1:0] control_seq1;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        kind_t              out_kind;
        logic [BYTE_W-1:0]  payload_byte;
        logic               seq_bit;
        status_t            frame_status;
        logic [COUNT_W-1:0] payload_count;
    } result_t;

endpackage

// ===== rtl/ifdc_if.sv =====
// Channel interfaces: received line bytes in, deframer results out.
// Plain valid/ready handshake; no package dependency.
interface ifdc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifdc_res_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic        seq_bit;
    logic [1:0]  frame_status;
    logic [11:0] payload_count;

    modport source (output valid, output out_kind, output payload_byte, output seq_bit,
                    output frame_status, output payload_count, input ready);
    modport sink   (input valid, input out_kind, input payload_byte, input seq_bit,
                    input frame_status, input payload_count, output ready);
endinterface

// ===== rtl/ifdc_parser.sv =====
// Frame parser: header hunt, destuffing, hold-back of the check byte, running XOR.
// Depends on ifdc_pkg; the result it builds is registered by the top level.
module ifdc_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [ifdc_pkg::BYTE_W-1:0] rx_byte,
    input  ifdc_pkg::cfg_t              cfg,
    output ifdc_pkg::result_t           res
);
    import ifdc_pkg::*;

    phase_t             phase_reg, phase_next;
    logic               esc_reg, esc_next;
    logic [BYTE_W-1:0]  held_reg, held_next;
    logic               held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0]  check_reg, check_next;
    logic               seq_reg, seq_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               long_reg, long_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            esc_reg        <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            check_reg      <= '0;
            seq_reg        <= 1'b0;
            count_reg      <= '0;
            long_reg       <= 1'b0;
        end
        else if (take)
        begin
            phase_reg      <= phase_next;
            esc_reg        <= esc_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            check_reg      <= check_next;
            seq_reg        <= seq_next;
            count_reg      <= count_next;
            long_reg       <= long_next;
        end
    end

    logic              push;
    logic [BYTE_W-1:0] push_byte;
    logic [BYTE_W-1:0] unstuffed;
    logic [BYTE_W-1:0] frame_ctrl;

    always_comb
    begin
        phase_next      = phase_reg;
        esc_next        = esc_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        check_next      = check_reg;
        seq_next        = seq_reg;
        count_next      = count_reg;
        long_next       = long_reg;
        push            = 1'b0;
        push_byte       = rx_byte;
        unstuffed       = rx_byte ^ cfg.stuff_mask;
        frame_ctrl      = seq_reg ? cfg.control_seq1 : cfg.control_seq0;
        res             = '0;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == cfg.flag_value)
                    phase_next = PH_FLAG;
            end
            PH_FLAG:
            begin
                if (rx_byte == cfg.address_value)
                    phase_next = PH_ADDR;
                else if (rx_byte != cfg.flag_value)
                    phase_next = PH_HUNT;
            end
            PH_ADDR:
            begin
                if (rx_byte == cfg.control_seq0 || rx_byte == cfg.control_seq1)
                begin
                    // equal control registers resolve to sequence 0
                    seq_next   = (rx_byte != cfg.control_seq0);
                    phase_next = PH_CTRL;
                end
                else if (rx_byte == cfg.flag_value)
                    phase_next = PH_FLAG;
                else
                    phase_next = PH_HUNT;
            end
            PH_CTRL:
            begin
                if (rx_byte == (cfg.address_value ^ frame_ctrl))
                begin
                    esc_next        = 1'b0;
                    held_next       = '0;
                    held_valid_next = 1'b0;
                    check_next      = '0;
                    count_next      = '0;
                    long_next       = 1'b0;
                    phase_next      = PH_BODY;
                end
                else if (rx_byte == cfg.flag_value)
                    phase_next = PH_FLAG;
                else
                    phase_next = PH_HUNT;
            end
            PH_BODY:
            begin
                if (rx_byte == cfg.flag_value)
                begin
                    // closing flag; an empty body reports nothing
                    if (held_valid_reg)
                    begin
                        res.valid         = 1'b1;
                        res.out_kind      = KIND_END;
                        res.seq_bit       = seq_reg;
                        res.payload_count = count_reg;
                        if (long_reg)
                            res.frame_status = ST_TOO_LONG;
                        else if (held_reg != check_reg)
                            res.frame_status = ST_MISMATCH;
                        else
                            res.frame_status = ST_GOOD;
                    end
                    esc_next        = 1'b0;
                    held_next       = '0;
                    held_valid_next = 1'b0;
                    check_next      = '0;
                    count_next      = '0;
                    long_next       = 1'b0;
                    phase_next      = PH_FLAG;
                end
                else if (esc_reg)
                begin
                    esc_next  = 1'b0;
                    push_byte = unstuffed;
                    push      = (unstuffed == cfg.flag_value)
                             || (unstuffed == cfg.escape_value);
                end
                else if (rx_byte == cfg.escape_value)
                    esc_next = 1'b1;
                else
                    push = 1'b1;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        // held byte goes out once its successor arrives
        if (push)
        begin
            if (held_valid_reg)
            begin
                if (count_reg < MAX_PAYLOAD)
                begin
                    res.valid        = 1'b1;
                    res.out_kind     = KIND_DATA;
                    res.payload_byte = held_reg;
                    check_next       = check_reg ^ held_reg;
                    count_next       = count_reg + COUNT_W'(1);
                end
                else
                    long_next = 1'b1;
            end
            held_next       = push_byte;
            held_valid_next = 1'b1;
        end
    end

endmodule

// ===== rtl/info_frame_deframer_checker.sv =====
// Top level of the info frame deframer and checker: config registers, parser, result register.
// Depends on ifdc_pkg, ifdc_if.sv, ifdc_parser and the assertion macro header.
`include "info_frame_deframer_checker_macros.svh"

// Receive-side deframer for an HDLC-like link with XOR block checks. One raw line
// byte is taken per clock: the rx channel is ready whenever the result register is
// empty or its contents are being taken in the same cycle, so with an always-ready
// sink the block runs at one byte per cycle, and each byte's result (at most one)
// appears on the res channel in the cycle after its transaction. The parse step is
// combinational, so the result register is the only register on the way. A frame is
// flag, address, control (sequence 0 or 1), header check = address XOR control, a
// stuffed body and a closing flag; the last body byte is the data check and is never
// given out. Data items carry out_kind 0 and the destuffed byte; the end item carries
// out_kind 1, the sequence bit, the payload count and the status (good, check
// mismatch, too long beyond 2048 bytes). Bad escape pairs are dropped, empty bodies
// report nothing, and a closing flag opens the next frame. Configuration is written
// through cfg_we/cfg_index/cfg_data, one register per clock, unknown indexes ignored.
module info_frame_deframer_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    ifdc_rx_if.sink                      rx,
    ifdc_res_if.source                   res,
    input  logic                         cfg_we,
    input  logic [ifdc_pkg::INDEX_W-1:0] cfg_index,
    input  logic [ifdc_pkg::BYTE_W-1:0]  cfg_data
);
    import ifdc_pkg::*;

    // Configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_value    <= RST_FLAG;
            cfg_reg.escape_value  <= RST_ESCAPE;
            cfg_reg.stuff_mask    <= RST_MASK;
            cfg_reg.address_value <= RST_ADDRESS;
            cfg_reg.control_seq0  <= RST_CTRL0;
            cfg_reg.control_seq1  <= RST_CTRL1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLAG:    cfg_reg.flag_value    <= cfg_data;
                CFG_ESCAPE:  cfg_reg.escape_value  <= cfg_data;
                CFG_MASK:    cfg_reg.stuff_mask    <= cfg_data;
                CFG_ADDRESS: cfg_reg.address_value <= cfg_data;
                CFG_CTRL0:   cfg_reg.control_seq0  <= cfg_data;
                CFG_CTRL1:   cfg_reg.control_seq1  <= cfg_data;
                default:     ; // writes beyond the register list are dropped
            endcase
        end
    end

    // Handshake: take a byte whenever the result slot frees up this cycle
    logic    take;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t step_res;

    assign rx.ready = !out_valid_reg || res.ready;
    assign take     = rx.valid && rx.ready;

    ifdc_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx.rx_byte),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

    // Result register: loaded when a byte produces an item, cleared once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rx.ready)
            out_valid_next = take && step_res.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (take && step_res.valid)
            out_reg <= step_res;
    end

    assign res.valid         = out_valid_reg;
    assign res.out_kind      = out_reg.out_kind;
    assign res.payload_byte  = out_reg.payload_byte;
    assign res.seq_bit       = out_reg.seq_bit;
    assign res.frame_status  = out_reg.frame_status;
    assign res.payload_count = out_reg.payload_count;

    // Checks on the block's own logic
    `IFDC_ASSERT_NOW(a_stall_blocks_rx, res.valid && !res.ready, !rx.ready,
        "byte accepted while a result is stalled")
    `IFDC_ASSERT_NEXT(a_item_reaches_out, take && step_res.valid, res.valid,
        "parser item did not reach the result register")
    `IFDC_ASSERT_NOW(a_end_fields, res.valid && res.out_kind == KIND_END,
        res.payload_byte == '0 && res.frame_status != 2'd3,
        "end item carries a data byte or an illegal status")
    `IFDC_ASSERT_NOW(a_data_fields, res.valid && res.out_kind == KIND_DATA,
        !res.seq_bit && res.frame_status == ST_GOOD && res.payload_count == '0,
        "data item carries end-of-frame fields")

endmodule
